### sv/gpf_pkg.sv
// Shared codes and types for the Goldbach prime pair finder.
`default_nettype none

package gpf_pkg;

  // result status codes
  localparam logic [1:0] STATUS_FOUND = 2'd0;
  localparam logic [1:0] STATUS_NONE  = 2'd1;
  localparam logic [1:0] STATUS_ODD   = 2'd2;

  // class assigned by the front end
  localparam logic [1:0] KIND_EVEN  = 2'd0;
  localparam logic [1:0] KIND_ODD   = 2'd1;
  localparam logic [1:0] KIND_SMALL = 2'd2;

  // queue between front and search engine
  localparam int Q_DEPTH = 2;
  localparam int Q_AW    = 1;

  localparam int SMALL_BITS = 15;
  localparam int LARGE_BITS = 16;
  localparam int IN_BITS    = 16;

  typedef struct packed {
    logic       valid;
    logic [1:0] kind;
  } q_ctl_t;

endpackage

`default_nettype wire

### sv/gpf_front.sv
// Front end: takes input words, classifies them and queues them for the search engine.
`default_nettype none

module gpf_front #(
  parameter int UW = 16
) (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              in_valid,
  output logic                             in_ready,
  input  wire [gpf_pkg::IN_BITS-1:0]       even_value,
  output gpf_pkg::q_ctl_t                  q_ctl,
  output logic [UW-1:0]                    q_value,
  input  wire                              q_pop
);

  logic [UW-1:0]         mem_value [gpf_pkg::Q_DEPTH];
  logic [1:0]            mem_kind  [gpf_pkg::Q_DEPTH];
  logic [gpf_pkg::Q_AW-1:0] wr_ptr;
  logic [gpf_pkg::Q_AW-1:0] rd_ptr;
  logic [gpf_pkg::Q_AW:0]   count;
  logic [UW-1:0]         value_in;
  logic [1:0]            kind_in;
  logic                  push;
  logic                  pop;

  assign value_in = even_value[UW-1:0];

  always_comb begin
    if (value_in[0]) begin
      kind_in = gpf_pkg::KIND_ODD;
    end else if (value_in < UW'(4)) begin
      // zero and two: no candidate in range
      kind_in = gpf_pkg::KIND_SMALL;
    end else begin
      kind_in = gpf_pkg::KIND_EVEN;
    end
  end

  assign in_ready = (count != (gpf_pkg::Q_AW+1)'(gpf_pkg::Q_DEPTH));
  assign push     = in_valid && in_ready;
  assign pop      = q_pop && (count != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_value[wr_ptr] <= value_in;
      mem_kind[wr_ptr]  <= kind_in;
    end
  end

  assign q_ctl.valid = (count != '0);
  assign q_ctl.kind  = mem_kind[rd_ptr];
  assign q_value     = mem_value[rd_ptr];

endmodule

`default_nettype wire

### sv/gpf_trial_mod.sv
// Bit-serial restoring remainder unit: dividend mod divisor, one quotient bit per cycle.
`default_nettype none

module gpf_trial_mod #(
  parameter int UW = 16,
  parameter int DW = 9
) (
  input  wire            clk,
  input  wire            rst,
  input  wire            start,
  input  wire [UW-1:0]   dividend,
  input  wire [DW-1:0]   divisor,
  output logic           done,
  output logic [DW-1:0]  rem
);

  localparam int CW = $clog2(UW + 1);

  logic          busy;
  logic [CW-1:0] cnt;
  logic [UW-1:0] shreg;
  logic [DW-1:0] dvs;
  logic [DW:0]   trial;
  logic [DW-1:0] rem_next;

  assign trial = {rem, shreg[UW-1]};

  always_comb begin
    if (trial >= {1'b0, dvs}) begin
      rem_next = DW'(trial - {1'b0, dvs});
    end else begin
      rem_next = trial[DW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(UW);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= '0;
      shreg <= dividend;
      dvs   <= divisor;
    end else if (busy) begin
      rem   <= rem_next;
      shreg <= shreg << 1;
    end
  end

endmodule

`default_nettype wire

### sv/gpf_search.sv
// Search engine: walks candidates, runs trial division on both halves, holds the result word.
`default_nettype none

module gpf_search #(
  parameter int UW = 16,
  parameter int DW = 9
) (
  input  wire                                clk,
  input  wire                                rst,
  input  wire gpf_pkg::q_ctl_t               q_ctl,
  input  wire [UW-1:0]                       q_value,
  output logic                               q_pop,
  output logic                               out_valid,
  input  wire                                out_ready,
  output logic [1:0]                         status,
  output logic [gpf_pkg::SMALL_BITS-1:0]     small_prime,
  output logic [gpf_pkg::LARGE_BITS-1:0]     large_prime
);

  localparam int SW = 2 * DW;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_DIV   = 3'd2;
  localparam logic [2:0] S_DONE  = 3'd3;

  logic [2:0]    state;
  logic [UW-1:0] value;
  logic [UW-2:0] half;
  logic [UW-2:0] p;
  logic [UW-1:0] tv;
  logic          side;
  logic [DW-1:0] d;
  logic [SW-1:0] sq;
  logic [1:0]    res_status;
  logic [UW-2:0] res_small;
  logic [UW-1:0] res_large;
  logic          div_start;
  logic          div_done;
  logic [DW-1:0] div_rem;
  logic [UW-1:0] partner;
  logic [UW-2:0] p_inc;
  logic          sq_over;
  logic          out_free;

  assign partner  = value - UW'(p);
  assign p_inc    = p + (UW-1)'(1);
  assign sq_over  = sq > SW'(tv);
  assign out_free = !out_valid || out_ready;

  assign q_pop     = (state == S_IDLE) && q_ctl.valid;
  assign div_start = (state == S_CHECK) && !sq_over;

  gpf_trial_mod #(
    .UW(UW),
    .DW(DW)
  ) u_mod (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (tv),
    .divisor  (d),
    .done     (div_done),
    .rem      (div_rem)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (q_ctl.valid) begin
            value <= q_value;
            half  <= q_value[UW-1:1];
            p     <= (UW-1)'(2);
            tv    <= UW'(2);
            side  <= 1'b0;
            d     <= DW'(2);
            sq    <= SW'(4);
            res_small <= '0;
            res_large <= '0;
            if (q_ctl.kind == gpf_pkg::KIND_ODD) begin
              res_status <= gpf_pkg::STATUS_ODD;
              state      <= S_DONE;
            end else if (q_ctl.kind == gpf_pkg::KIND_SMALL) begin
              res_status <= gpf_pkg::STATUS_NONE;
              state      <= S_DONE;
            end else begin
              state <= S_CHECK;
            end
          end
        end
        S_CHECK: begin
          if (sq_over) begin
            // tv is prime
            if (!side) begin
              side <= 1'b1;
              tv   <= partner;
              d    <= DW'(2);
              sq   <= SW'(4);
            end else begin
              res_status <= gpf_pkg::STATUS_FOUND;
              res_small  <= p;
              res_large  <= partner;
              state      <= S_DONE;
            end
          end else begin
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_done) begin
            if (div_rem == '0) begin
              // composite: move to next candidate
              if (p == half) begin
                res_status <= gpf_pkg::STATUS_NONE;
                state      <= S_DONE;
              end else begin
                p     <= p_inc;
                tv    <= UW'(p_inc);
                side  <= 1'b0;
                d     <= DW'(2);
                sq    <= SW'(4);
                state <= S_CHECK;
              end
            end else begin
              // (d+1)^2 = d^2 + 2d + 1
              d     <= d + 1'b1;
              sq    <= sq + SW'({d, 1'b1});
              state <= S_CHECK;
            end
          end
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      status      <= res_status;
      small_prime <= gpf_pkg::SMALL_BITS'(res_small);
      large_prime <= gpf_pkg::LARGE_BITS'(res_large);
    end
  end

endmodule

`default_nettype wire

### sv/goldbach_prime_pair_finder.sv
// Top level: Goldbach prime pair finder, front queue plus trial-division search engine.
// Timing: odd, zero and two skip the search and go straight to a result; an even word
//   walks candidates, each checked by the bit-serial remainder unit one trial divisor at
//   a time over VALUE_BITS bits, with VALUE_BITS capped at 16.
// Throughput: one word at a time in the search engine; a 2-deep queue takes words meanwhile.
// Reset: synchronous, empties the queue, idles the engine and drops any pending result.
`default_nettype none

module goldbach_prime_pair_finder #(
  parameter int VALUE_BITS = 16
) (
  input  wire                                clk,
  input  wire                                rst,
  input  wire                                in_valid,
  output logic                               in_ready,
  input  wire [gpf_pkg::IN_BITS-1:0]         even_value,
  output logic                               out_valid,
  input  wire                                out_ready,
  output logic [1:0]                         status,
  output logic [gpf_pkg::SMALL_BITS-1:0]     small_prime,
  output logic [gpf_pkg::LARGE_BITS-1:0]     large_prime
);

  // bits above the input field carry nothing
  localparam int UW = (VALUE_BITS < gpf_pkg::IN_BITS) ? VALUE_BITS : gpf_pkg::IN_BITS;
  localparam int DW = (UW + 1) / 2 + 1;

  gpf_pkg::q_ctl_t q_ctl;
  logic [UW-1:0]   q_value;
  logic            q_pop;

  gpf_front #(
    .UW(UW)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .even_value (even_value),
    .q_ctl      (q_ctl),
    .q_value    (q_value),
    .q_pop      (q_pop)
  );

  gpf_search #(
    .UW(UW),
    .DW(DW)
  ) u_search (
    .clk         (clk),
    .rst         (rst),
    .q_ctl       (q_ctl),
    .q_value     (q_value),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .status      (status),
    .small_prime (small_prime),
    .large_prime (large_prime)
  );

endmodule

`default_nettype wire

### verif/goldbach_prime_pair_finder_tb.sv
// Testbench for goldbach_prime_pair_finder: directed table, then random words, all scored.
`timescale 1ns / 1ps

module goldbach_prime_pair_finder_tb;

  localparam int CLK_PERIOD   = 8;
  localparam int RESET_CYCLES = 11;
  localparam int RANDOM_WORDS = 122;
  localparam int MAX_GAP      = 13;
  localparam int HOLD_AT      = 30;      // result count at which the sink holds off
  localparam int HOLD_CYCLES  = 20000;   // long enough for the engine to fill the queue
  localparam int DRAIN_AT     = 70;      // random word after which the source waits for all
  localparam int TAIL_CYCLES  = 64;
  localparam int IDLE_LIMIT   = 3000000; // worst 16-bit search, with margin
  localparam int DIR_ROWS     = 18;

  typedef struct packed {
    logic [1:0]                     status;
    logic [gpf_pkg::SMALL_BITS-1:0] small_p;
    logic [gpf_pkg::LARGE_BITS-1:0] large_p;
  } pair_result_t;

  typedef struct packed {
    logic [gpf_pkg::IN_BITS-1:0] value;
    logic                        typed;   // result below is given, else predicted
    pair_result_t                result;
  } dir_row_t;

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           in_valid = 1'b0;
  logic                           in_ready;
  logic [gpf_pkg::IN_BITS-1:0]    even_value = '0;
  logic                           out_valid;
  logic                           out_ready = 1'b0;
  logic [1:0]                     status;
  logic [gpf_pkg::SMALL_BITS-1:0] small_prime;
  logic [gpf_pkg::LARGE_BITS-1:0] large_prime;

  pair_result_t pair_expect_q[$];
  int           err_count = 0;
  int           rx_count = 0;
  int           idle_cycles = 0;
  bit           hold_off = 1'b0;
  bit           tx_quiet = 1'b0;
  bit           rx_quiet = 1'b0;

  dir_row_t dir_rows [DIR_ROWS] = '{
    '{16'd0,     1'b1, '{gpf_pkg::STATUS_NONE,  15'd0, 16'd0}},
    '{16'd2,     1'b1, '{gpf_pkg::STATUS_NONE,  15'd0, 16'd0}},
    '{16'd1,     1'b1, '{gpf_pkg::STATUS_ODD,   15'd0, 16'd0}},
    '{16'hFFFF,  1'b1, '{gpf_pkg::STATUS_ODD,   15'd0, 16'd0}},
    '{16'h5555,  1'b1, '{gpf_pkg::STATUS_ODD,   15'd0, 16'd0}},
    '{16'd3,     1'b1, '{gpf_pkg::STATUS_ODD,   15'd0, 16'd0}},
    '{16'd4,     1'b1, '{gpf_pkg::STATUS_FOUND, 15'd2, 16'd2}},
    '{16'd6,     1'b1, '{gpf_pkg::STATUS_FOUND, 15'd3, 16'd3}},
    '{16'd8,     1'b1, '{gpf_pkg::STATUS_FOUND, 15'd3, 16'd5}},
    '{16'd10,    1'b0, '0},
    '{16'd12,    1'b0, '0},
    '{16'd98,    1'b0, '0},
    '{16'd128,   1'b0, '0},
    '{16'd1024,  1'b0, '0},
    '{16'hAAAA,  1'b0, '0},
    '{16'd32768, 1'b0, '0},
    '{16'hFFFE,  1'b0, '0},
    '{16'hFFFC,  1'b0, '0}
  };

  goldbach_prime_pair_finder u_top (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .even_value  (even_value),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .status      (status),
    .small_prime (small_prime),
    .large_prime (large_prime)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  function automatic bit is_prime_num(input int unsigned n);
    int unsigned d;
    if (n < 2) return 1'b0;
    for (d = 2; d * d <= n; d++) begin
      if (n % d == 0) return 1'b0;
    end
    return 1'b1;
  endfunction

  // first p in 2..v/2 with p and v-p both prime, odd v gives ODD; input is already VALUE_BITS wide
  function automatic pair_result_t predict_pair(input logic [gpf_pkg::IN_BITS-1:0] v);
    pair_result_t r;
    int unsigned  p;
    int unsigned  n;
    n = v;
    r = '{gpf_pkg::STATUS_NONE, '0, '0};
    if (v[0]) begin
      r.status = gpf_pkg::STATUS_ODD;
      return r;
    end
    for (p = 2; p <= n / 2; p++) begin
      if (is_prime_num(p) && is_prime_num(n - p)) begin
        r.status  = gpf_pkg::STATUS_FOUND;
        r.small_p = p[gpf_pkg::SMALL_BITS-1:0];
        r.large_p = gpf_pkg::LARGE_BITS'(n - p);
        return r;
      end
    end
    return r;
  endfunction

  // mostly small values keep the search short; a few use the full range
  function automatic logic [gpf_pkg::IN_BITS-1:0] random_value();
    logic [gpf_pkg::IN_BITS-1:0] v;
    int                          sel;
    sel = $urandom_range(0, 99);
    if (sel < 60) v = gpf_pkg::IN_BITS'($urandom_range(0, 511));
    else if (sel < 85) v = gpf_pkg::IN_BITS'($urandom_range(0, 8191));
    else v = gpf_pkg::IN_BITS'($urandom_range(0, 65535));
    if ($urandom_range(0, 4) != 0) v[0] = 1'b0;
    return v;
  endfunction

  task automatic send_word(input logic [gpf_pkg::IN_BITS-1:0] v, input pair_result_t want);
    int gap;
    if ($urandom_range(0, 15) == 0) tx_quiet = !tx_quiet;
    gap = (hold_off || tx_quiet) ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    even_value <= v;
    do @(posedge clk); while (!in_ready);
    pair_expect_q.push_back(want);
  endtask

  task automatic receive_words();
    pair_result_t want;
    int           stall;
    forever begin
      if ($urandom_range(0, 15) == 0) rx_quiet = !rx_quiet;
      stall = rx_quiet ? 0 : $urandom_range(0, MAX_GAP);
      if (rx_count == HOLD_AT) begin
        hold_off = 1'b1;
        stall    = HOLD_CYCLES;
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      hold_off = 1'b0;
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      rx_count++;
      if (pair_expect_q.size() == 0) begin
        $display("%0t: unexpected word status %0d small %0d large %0d",
                 $time, status, small_prime, large_prime);
        err_count++;
      end else begin
        want = pair_expect_q.pop_front();
        if (status !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, status);
          err_count++;
        end
        if (small_prime !== want.small_p) begin
          $display("%0t: small_prime expected %0d actual %0d",
                   $time, want.small_p, small_prime);
          err_count++;
        end
        if (large_prime !== want.large_p) begin
          $display("%0t: large_prime expected %0d actual %0d",
                   $time, want.large_p, large_prime);
          err_count++;
        end
      end
    end
  endtask

  // no word moving on either side for too long means the block is stuck
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles + 1 >= IDLE_LIMIT) begin
        $display("goldbach_prime_pair_finder_tb failed");
        $finish;
      end
    end
  end

  initial begin
    logic [gpf_pkg::IN_BITS-1:0] v;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    fork
      receive_words();
      begin
        for (int i = 0; i < DIR_ROWS; i++) begin
          send_word(dir_rows[i].value,
                    dir_rows[i].typed ? dir_rows[i].result : predict_pair(dir_rows[i].value));
        end
        for (int i = 0; i < RANDOM_WORDS; i++) begin
          v = random_value();
          send_word(v, predict_pair(v));
          if (i == DRAIN_AT) begin
            in_valid <= 1'b0;
            while (pair_expect_q.size() != 0) @(posedge clk);
          end
        end
      end
    join_any
    in_valid <= 1'b0;
    while (pair_expect_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("goldbach_prime_pair_finder_tb passed");
    end else begin
      $display("goldbach_prime_pair_finder_tb failed");
    end
    $finish;
  end

endmodule

### sim.f
sv/gpf_pkg.sv
sv/gpf_front.sv
sv/gpf_trial_mod.sv
sv/gpf_search.sv
sv/goldbach_prime_pair_finder.sv
verif/goldbach_prime_pair_finder_tb.sv
